@@ rtl/core/bet_pkg.sv @@
// ----------------------------------------------------------------------------
// bet_pkg
// Types, event codes and parse modes shared by the bencode tokenizer modules.
// ----------------------------------------------------------------------------
package bet_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [3:0] {
		EV_INT          = 4'd0,
		EV_STRING       = 4'd1,
		EV_LIST         = 4'd2,
		EV_DICT         = 4'd3,
		EV_END          = 4'd4,
		EV_DONE         = 4'd5,
		EV_BAD_BYTE     = 4'd6,
		EV_BAD_INT_BYTE = 4'd7,
		EV_EOF          = 4'd8,
		EV_TOO_LONG     = 4'd9,
		EV_OVERFLOW     = 4'd10
	} ev_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE       = 3'd0,
		MODE_INT_START  = 3'd1,
		MODE_INT_DIGITS = 3'd2,
		MODE_STR_LEN    = 3'd3,
		MODE_STR_BODY   = 3'd4,
		MODE_ERROR      = 3'd5
	} mode_t;

	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0]        event_kind;
		logic signed [63:0] int_value;
		logic [31:0]       byte_offset;
		logic [31:0]       string_length;
		logic              last_of_run;
	} out_item_t;

	// one queue entry: up to two events caused by one byte
	typedef struct packed {
		logic      two;
		out_item_t ev0;
		out_item_t ev1;
	} qent_t;

endpackage

@@ rtl/core/bet_front.sv @@
// ----------------------------------------------------------------------------
// bet_front
// Parses one byte per cycle while ent_ready is high and builds the events it causes as one entry.
// ----------------------------------------------------------------------------
module bet_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  bet_pkg::in_item_t in_item,
	output logic              ent_valid,
	input  logic              ent_ready,
	output logic              ent_has,
	output bet_pkg::qent_t    ent
);
	import bet_pkg::*;

	mode_t                  mode_q, mode_d;
	logic [63:0]            mag_q, mag_d;
	logic                   neg_q, neg_d;
	logic [31:0]            rem_q, rem_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [31:0]            maxlen_q;
	logic                   fire;

	logic [7:0]             b;
	logic                   dig;
	logic [3:0]             dv;
	logic [OFFSET_BITS-1:0] pos1;
	logic [67:0]            m10;
	logic [64:0]            lim;
	logic                   ovf;
	logic [31:0]            rem_m1;
	out_item_t              e0, e1;
	logic                   has0, has1;

	assign in_ready  = ent_ready;
	assign ent_valid = in_valid;
	assign fire      = in_valid && ent_ready;
	// entry carries at least one event
	assign ent_has   = has0 || has1;

	// byte classification and arithmetic
	always_comb begin
		b    = in_item.data_byte;
		dig  = (b >= CH_ZERO) && (b <= CH_NINE);
		dv   = dig ? 4'(b - CH_ZERO) : 4'd0;
		pos1 = pos_q + OFFSET_BITS'(1);
		m10  = {mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + 68'(dv);
		// magnitude*10+d must not exceed limit
		lim  = neg_q ? 65'h0_8000_0000_0000_0000 : 65'h0_7FFF_FFFF_FFFF_FFFF;
		ovf  = (m10 > 68'(lim));
		rem_m1 = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;
	end

	// next state and events
	always_comb begin
		mode_d  = mode_q;
		mag_d   = mag_q;
		neg_d   = neg_q;
		rem_d   = rem_q;
		start_d = start_q;
		e0      = '0;
		e1      = '0;
		has0    = 1'b0;
		has1    = 1'b0;
		unique case (mode_q)
			MODE_IDLE: begin
				if (b == CH_I) begin
					mag_d  = '0;
					neg_d  = 1'b0;
					mode_d = MODE_INT_START;
				end else if (b == CH_L) begin
					has0 = 1'b1; e0.event_kind = EV_LIST;
				end else if (b == CH_D) begin
					has0 = 1'b1; e0.event_kind = EV_DICT;
				end else if (b == CH_E) begin
					has0 = 1'b1; e0.event_kind = EV_END;
				end else if (dig) begin
					mag_d  = 64'(dv);
					mode_d = MODE_STR_LEN;
				end else begin
					has0 = 1'b1; e0.event_kind = EV_BAD_BYTE;
					e0.byte_offset = 32'(pos_q);
					mode_d = MODE_ERROR;
				end
			end
			MODE_INT_START, MODE_INT_DIGITS: begin
				if (mode_q == MODE_INT_START && b == CH_MINUS) begin
					neg_d  = 1'b1;
					mode_d = MODE_INT_DIGITS;
				end else if (b == CH_E) begin
					has0 = 1'b1; e0.event_kind = EV_INT;
					e0.int_value = neg_q ? -$signed(mag_q) : $signed(mag_q);
					mode_d = MODE_IDLE;
					mag_d = '0; neg_d = 1'b0; rem_d = '0; start_d = '0;
				end else if (dig) begin
					if (ovf) begin
						has0 = 1'b1; e0.event_kind = EV_OVERFLOW;
						e0.byte_offset = 32'(pos_q);
						mode_d = MODE_ERROR;
					end else begin
						mag_d  = m10[63:0];
						mode_d = MODE_INT_DIGITS;
					end
				end else begin
					has0 = 1'b1; e0.event_kind = EV_BAD_INT_BYTE;
					e0.byte_offset = 32'(pos_q);
					mode_d = MODE_ERROR;
				end
			end
			MODE_STR_LEN: begin
				if (b == CH_COLON) begin
					if (mag_q > 64'(maxlen_q)) begin
						has0 = 1'b1; e0.event_kind = EV_TOO_LONG;
						e0.string_length = mag_q[32] ? 32'hFFFF_FFFF : mag_q[31:0];
						mode_d = MODE_ERROR;
					end else if (mag_q == 64'd0) begin
						has0 = 1'b1; e0.event_kind = EV_STRING;
						e0.byte_offset = 32'(pos1);
						mode_d = MODE_IDLE;
						mag_d = '0; neg_d = 1'b0; rem_d = '0; start_d = '0;
					end else begin
						start_d = pos1;
						rem_d   = mag_q[31:0];
						mode_d  = MODE_STR_BODY;
					end
				end else if (dig) begin
					// length saturates at 2^32
					mag_d = (m10 >= 68'h1_0000_0000) ? 64'h1_0000_0000 : m10[63:0];
				end else begin
					has0 = 1'b1; e0.event_kind = EV_BAD_INT_BYTE;
					e0.byte_offset = 32'(pos_q);
					mode_d = MODE_ERROR;
				end
			end
			MODE_STR_BODY: begin
				rem_d = rem_m1;
				if (rem_m1 == 32'd0) begin
					has0 = 1'b1; e0.event_kind = EV_STRING;
					e0.byte_offset   = 32'(start_q);
					e0.string_length = mag_q[31:0];
					mode_d = MODE_IDLE;
					mag_d = '0; neg_d = 1'b0; rem_d = '0; start_d = '0;
				end
			end
			default: mode_d = MODE_ERROR;
		endcase

		// end of buffer
		if (in_item.final_byte) begin
			if (mode_d == MODE_IDLE) begin
				has1 = 1'b1; e1.event_kind = EV_DONE;
			end else if (mode_d == MODE_INT_START || mode_d == MODE_INT_DIGITS ||
			             mode_d == MODE_STR_LEN) begin
				has1 = 1'b1; e1.event_kind = EV_EOF;
			end else if (mode_d == MODE_STR_BODY) begin
				has1 = 1'b1; e1.event_kind = EV_TOO_LONG;
				e1.string_length = mag_d[31:0];
			end
			mode_d = MODE_IDLE;
			mag_d = '0; neg_d = 1'b0; rem_d = '0; start_d = '0;
		end

		// pack: a single event always goes in ev0
		ent = '0;
		if (has0) begin
			ent.ev0 = e0;
			ent.ev1 = e1;
			ent.two = has1;
			ent.ev0.last_of_run = !has1;
			ent.ev1.last_of_run = 1'b1;
		end else begin
			ent.ev0 = e1;
			ent.ev0.last_of_run = 1'b1;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			mag_q    <= '0;
			neg_q    <= 1'b0;
			rem_q    <= '0;
			start_q  <= '0;
			pos_q    <= '0;
			maxlen_q <= 32'hFFFF_FFFF;
		end else begin
			if (cfg_we)
				maxlen_q <= cfg_data;
			if (fire) begin
				mode_q  <= mode_d;
				mag_q   <= mag_d;
				neg_q   <= neg_d;
				rem_q   <= rem_d;
				start_q <= start_d;
				pos_q   <= in_item.final_byte ? '0 : pos1;
			end
		end
	end

endmodule

@@ rtl/core/bet_back.sv @@
// ----------------------------------------------------------------------------
// bet_back
// Event queue and output stage: unpacks one or two events per entry.
// ----------------------------------------------------------------------------
module bet_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ent_valid,
	output logic               ent_ready,
	input  logic               ent_has,
	input  bet_pkg::qent_t     ent,
	output logic               out_valid,
	input  logic               out_ready,
	output bet_pkg::out_item_t out_item
);
	import bet_pkg::*;

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic              sub_q;
	logic              push, pop, adv;
	qent_t             head;

	assign head      = mem_q[rp_q];
	assign ent_ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	// entries with no event are dropped on entry
	assign push      = ent_valid && ent_ready && ent_has;
	assign out_valid = (cnt_q != '0);
	assign out_item  = sub_q ? head.ev1 : head.ev0;
	assign adv       = out_valid && out_ready;
	assign pop       = adv && (sub_q || !head.two);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= ent;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
			sub_q <= 1'b0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop) begin
				rp_q  <= rp_q + 1'b1;
				sub_q <= 1'b0;
			end else if (adv) begin
				sub_q <= 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

@@ rtl/core/bencode_event_tokenizer_top.sv @@
// Event path: the events of an accepted byte are written into the event queue and offered from its head.
// Throughput: one byte per cycle while the event queue is not full; a byte that
// makes two events holds the queue head until both are taken, absorbed by a four-entry event queue.
// Reset: asynchronous, active low; parser idle at position zero,
// max_string_len at all ones, queue empty.
// ----------------------------------------------------------------------------
// bencode_event_tokenizer_top
// Streaming bencode tokenizer: byte parser front, event queue back.
// ----------------------------------------------------------------------------
module bencode_event_tokenizer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  bet_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output bet_pkg::out_item_t out_item
);
	import bet_pkg::*;

	logic  ent_valid, ent_ready, ent_has;
	qent_t ent;

	bet_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_data, .in_valid, .in_ready, .in_item,
		.ent_valid, .ent_ready, .ent_has, .ent
	);

	bet_back u_back (
		.clk, .arst_n, .ent_valid, .ent_ready, .ent_has, .ent,
		.out_valid, .out_ready, .out_item
	);

endmodule
